[rtl/indexed_bmp_stream_decoder_unit_defines.svh]
// assertion helpers shared by the decoder rtl
`ifndef INDEXED_BMP_STREAM_DECODER_UNIT_DEFINES_SVH
`define INDEXED_BMP_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define IBSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define IBSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ibsd_pkg.sv]
package ibsd_pkg;

   localparam int DimBitsDefault   = 16;
   localparam int MaxColorsDefault = 256;
   localparam int HeaderBytes      = 54;
   localparam int HdrCountBits     = $clog2(HeaderBytes);

   // header field locations (first byte of each little-endian field; the *TopByte ones mark its last byte)
   localparam int WidthLo     = 18;
   localparam int HeightLo    = 22;
   localparam int BppLo       = 28;
   localparam int BppTopByte  = 29;
   localparam int CompLo      = 30;
   localparam int CompTopByte = 33;
   localparam int ColorsLo    = 46;

   localparam int PixelsPerByte = 8;
   localparam int SelBits       = $clog2(PixelsPerByte);
   localparam int QueueDepth    = 2;

   typedef enum logic [1:0] {
      KIND_PALETTE    = 2'd0,
      KIND_PIXEL      = 2'd1,
      KIND_BAD_FORMAT = 2'd2,
      KIND_BAD_SIZE   = 2'd3
   } kind_type;

   // all results caused by one input byte
   typedef struct packed {
      kind_type                             kind;
      logic [SelBits-1:0]                   last_sel;
      logic [15:0]                          pos_x;
      logic [15:0]                          pos_y;
      logic [PixelsPerByte-1:0][7:0]        pixels;
      logic [7:0]                           slot;
      logic [7:0]                           red;
      logic [7:0]                           green;
      logic [7:0]                           blue;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/ibsd_front.sv]
module ibsd_front #(
   parameter int DIM_BITS   = ibsd_pkg::DimBitsDefault,
   parameter int MAX_COLORS = ibsd_pkg::MaxColorsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                start_of_file,
   output logic                entry_valid,
   output ibsd_pkg::entry_type entry
);
   import ibsd_pkg::*;

   localparam int ColorBits = $clog2(MAX_COLORS + 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PALETTE,
      PH_PIXELS,
      PH_DONE,
      PH_REJECTED
   } phase_type;

   phase_type                     phase_ff, phase_in, phase_cur;
   logic [HdrCountBits-1:0]       hdr_ff, hdr_in, hdr_cur;
   logic [31:0]                   width_ff, width_in, height_ff, height_in;
   logic [31:0]                   comp_ff, comp_in, colors_ff, colors_in, colors_full;
   logic [15:0]                   bpp_ff, bpp_in;
   logic [ColorBits-1:0]          colors_eff_ff, colors_eff_in;
   logic [9:0]                    pal_count_ff, pal_count_in;
   logic [23:0]                   pal_bytes_ff, pal_bytes_in;
   logic [DIM_BITS-1:0]           column_ff, column_in, row_ff, row_in;
   logic [DIM_BITS-1:0]           width_lo, height_lo, remain, row_next;
   logic [2:0]                    bip_ff, bip_in, bip_w, bip_start;
   logic [7:0]                    acc_ff, acc_in, acc_w;
   logic [DIM_BITS:0]             row_bytes_ff, row_bytes_in;
   logic [DIM_BITS:0]             data_bytes_ff, data_bytes_in, total_bytes_ff, total_bytes_in;
   logic [DIM_BITS+3:0]           row_bits, data_sum, total_sum;
   logic [3:0]                    cnt_w;
   logic [PixelsPerByte-1:0][7:0] pix_w;
   logic                          in_data, size_bad;
   logic [8:0]                    slot_next;

   // row geometry, stable once the header is through
   assign width_lo       = width_ff[DIM_BITS-1:0];
   assign height_lo      = height_ff[DIM_BITS-1:0];
   assign row_bits       = (DIM_BITS+4)'(width_lo) * (DIM_BITS+4)'(bpp_ff[3:0]);
   assign data_sum       = row_bits + (DIM_BITS+4)'(7);
   assign total_sum      = row_bits + (DIM_BITS+4)'(31);
   assign data_bytes_in  = data_sum[DIM_BITS+3:3];
   assign total_bytes_in = {total_sum[DIM_BITS+3:5], 2'b00};
   assign bip_start      = bpp_ff[2:0] - 3'd1;
   assign remain         = width_lo - column_ff;
   assign in_data        = row_bytes_ff < data_bytes_ff;
   assign row_next       = row_ff + DIM_BITS'(1);
   assign slot_next      = {1'b0, pal_count_ff[9:2]} + 9'd1;

   always_comb begin
      colors_full = (colors_ff == 32'd0) ? (32'd1 << bpp_ff[2:0]) : colors_ff;
      size_bad    = ((width_ff >> DIM_BITS) != 32'd0) || ((height_ff >> DIM_BITS) != 32'd0) ||
                    (colors_full > 32'(MAX_COLORS));
   end

   // unpack one byte msb first, at most one pixel per bit
   always_comb begin
      acc_w = acc_ff;
      bip_w = bip_ff;
      cnt_w = '0;
      pix_w = '0;
      for (int k = 0; k < PixelsPerByte; k++) begin
         if (in_data && (DIM_BITS'(cnt_w) < remain)) begin
            acc_w = acc_w | (8'(data_byte[PixelsPerByte-1-k]) << bip_w);
            if (bip_w == 3'd0) begin
               pix_w[cnt_w[SelBits-1:0]] = acc_w;
               cnt_w = cnt_w + 4'd1;
               acc_w = '0;
               bip_w = bip_start;
            end else begin
               bip_w = bip_w - 3'd1;
            end
         end
      end
   end

   always_comb begin
      phase_cur     = start_of_file ? PH_HEADER : phase_ff;
      hdr_cur       = start_of_file ? '0 : hdr_ff;
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      bpp_in        = bpp_ff;
      comp_in       = comp_ff;
      colors_in     = colors_ff;
      colors_eff_in = colors_eff_ff;
      pal_count_in  = pal_count_ff;
      pal_bytes_in  = pal_bytes_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      bip_in        = bip_ff;
      acc_in        = acc_ff;
      row_bytes_in  = row_bytes_ff;
      entry_valid   = 1'b0;
      entry         = '0;
      if (take) begin
         phase_in = phase_cur;
         hdr_in   = hdr_cur;
         unique case (phase_cur)
            PH_HEADER: begin
               // every header field lane is written before it is looked at
               if (hdr_cur >= 6'(WidthLo) && hdr_cur <= 6'(WidthLo + 3)) begin
                  width_in[{2'(hdr_cur - 6'(WidthLo)), 3'b000} +: 8] = data_byte;
               end
               if (hdr_cur >= 6'(HeightLo) && hdr_cur <= 6'(HeightLo + 3)) begin
                  height_in[{2'(hdr_cur - 6'(HeightLo)), 3'b000} +: 8] = data_byte;
               end
               if (hdr_cur >= 6'(BppLo) && hdr_cur <= 6'(BppTopByte)) begin
                  bpp_in[{1'(hdr_cur - 6'(BppLo)), 3'b000} +: 8] = data_byte;
               end
               if (hdr_cur >= 6'(CompLo) && hdr_cur <= 6'(CompTopByte)) begin
                  comp_in[{2'(hdr_cur - 6'(CompLo)), 3'b000} +: 8] = data_byte;
               end
               if (hdr_cur >= 6'(ColorsLo) && hdr_cur <= 6'(ColorsLo + 3)) begin
                  colors_in[{2'(hdr_cur - 6'(ColorsLo)), 3'b000} +: 8] = data_byte;
               end
               if (hdr_cur == 6'(BppTopByte) && (bpp_in > 16'd8 || bpp_in == 16'd0)) begin
                  entry_valid = 1'b1;
                  entry.kind  = KIND_BAD_FORMAT;
                  phase_in    = PH_REJECTED;
               end else if (hdr_cur == 6'(CompTopByte) && comp_in != 32'd0) begin
                  entry_valid = 1'b1;
                  entry.kind  = KIND_BAD_FORMAT;
                  phase_in    = PH_REJECTED;
               end else if (hdr_cur >= 6'(HeaderBytes - 1)) begin
                  if (size_bad) begin
                     entry_valid = 1'b1;
                     entry.kind  = KIND_BAD_SIZE;
                     phase_in    = PH_REJECTED;
                  end else begin
                     phase_in      = PH_PALETTE;
                     pal_count_in  = '0;
                     colors_eff_in = ColorBits'(colors_full);
                  end
               end else begin
                  hdr_in = hdr_cur + 6'd1;
               end
            end
            PH_PALETTE: begin
               // entries arrive as blue, green, red, reserved
               if (pal_count_ff[1:0] != 2'd3) begin
                  pal_bytes_in[{pal_count_ff[1:0], 3'b000} +: 8] = data_byte;
                  pal_count_in = pal_count_ff + 10'd1;
               end else begin
                  entry_valid = 1'b1;
                  entry.kind  = KIND_PALETTE;
                  entry.slot  = pal_count_ff[9:2];
                  entry.red   = pal_bytes_ff[23:16];
                  entry.green = pal_bytes_ff[15:8];
                  entry.blue  = pal_bytes_ff[7:0];
                  if (slot_next >= 9'(colors_eff_ff)) begin
                     if (width_lo == '0 || height_lo == '0) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in     = PH_PIXELS;
                        row_in       = '0;
                        column_in    = '0;
                        row_bytes_in = '0;
                        acc_in       = '0;
                        bip_in       = bip_start;
                     end
                  end else begin
                     pal_count_in = pal_count_ff + 10'd1;
                  end
               end
            end
            PH_PIXELS: begin
               if (cnt_w != 4'd0) begin
                  entry_valid    = 1'b1;
                  entry.kind     = KIND_PIXEL;
                  entry.last_sel = SelBits'(cnt_w - 4'd1);
                  entry.pos_x    = 16'(column_ff);
                  entry.pos_y    = 16'(height_lo - row_ff - DIM_BITS'(1));
                  entry.pixels   = pix_w;
               end
               // end of the padded row: next row starts on a fresh byte
               if ((row_bytes_ff + (DIM_BITS+1)'(1)) >= total_bytes_ff) begin
                  row_in       = row_next;
                  column_in    = '0;
                  row_bytes_in = '0;
                  acc_in       = '0;
                  bip_in       = bip_start;
                  if (row_next >= height_lo) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  row_bytes_in = row_bytes_ff + (DIM_BITS+1)'(1);
                  column_in    = column_ff + DIM_BITS'(cnt_w);
                  acc_in       = acc_w;
                  bip_in       = bip_w;
               end
            end
            PH_DONE, PH_REJECTED: begin
               phase_in = phase_cur;
            end
            default: begin
               phase_in = PH_REJECTED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hdr_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
      end
      width_ff       <= width_in;
      height_ff      <= height_in;
      bpp_ff         <= bpp_in;
      comp_ff        <= comp_in;
      colors_ff      <= colors_in;
      colors_eff_ff  <= colors_eff_in;
      pal_count_ff   <= pal_count_in;
      pal_bytes_ff   <= pal_bytes_in;
      column_ff      <= column_in;
      row_ff         <= row_in;
      bip_ff         <= bip_in;
      acc_ff         <= acc_in;
      row_bytes_ff   <= row_bytes_in;
      data_bytes_ff  <= data_bytes_in;
      total_bytes_ff <= total_bytes_in;
   end

endmodule

[rtl/ibsd_queue.sv]
module ibsd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       write,
   input  ibsd_pkg::entry_type        wr_entry,
   input  logic                       read,
   output ibsd_pkg::entry_type        rd_entry,
   output ibsd_pkg::queue_status_type status
);
   import ibsd_pkg::*;

   localparam int PtrBits   = $clog2(QueueDepth);
   localparam int CountBits = $clog2(QueueDepth + 1);

   entry_type            entries_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign rd_entry     = entries_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CountBits'(QueueDepth);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (read) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (write && !read) begin
         count_in = count_ff + CountBits'(1);
      end else if (read && !write) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (write) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

[rtl/ibsd_back.sv]
module ibsd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ibsd_pkg::queue_status_type q_status,
   input  ibsd_pkg::entry_type        q_head,
   output logic                       q_read,
   input  logic                       pop,
   output logic                       empty,
   output logic [1:0]                 rsp_kind,
   output logic [15:0]                rsp_pos_x,
   output logic [15:0]                rsp_pos_y,
   output logic [7:0]                 rsp_pixel_index,
   output logic [7:0]                 rsp_palette_slot,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic                       rsp_last
);
   import ibsd_pkg::*;

   entry_type          cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [SelBits-1:0] sel_ff, sel_in;
   logic               at_last, advance, finish;

   assign at_last = sel_ff == cur_ff.last_sel;
   assign advance = cur_valid_ff && pop;
   // the next entry loads in the same cycle the last result leaves
   assign finish  = !cur_valid_ff || (advance && at_last);
   assign q_read  = finish && !q_status.empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      if (finish) begin
         cur_in       = q_head;
         cur_valid_in = !q_status.empty;
         sel_in       = '0;
      end else if (advance) begin
         sel_in = sel_ff + SelBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
      end
      cur_ff <= cur_in;
   end

   assign empty            = !cur_valid_ff;
   assign rsp_kind         = cur_ff.kind;
   assign rsp_pos_x        = cur_ff.pos_x + 16'(sel_ff);
   assign rsp_pos_y        = cur_ff.pos_y;
   assign rsp_pixel_index  = cur_ff.pixels[sel_ff];
   assign rsp_palette_slot = cur_ff.slot;
   assign rsp_red          = cur_ff.red;
   assign rsp_green        = cur_ff.green;
   assign rsp_blue         = cur_ff.blue;
   assign rsp_last         = at_last;

endmodule

[rtl/indexed_bmp_stream_decoder_unit.sv]
// Indexed bitmap decoder: takes a bitmap file one byte per transaction (start_of_file marks
// byte 0), parses the 54-byte header, then gives one result per palette entry and one per
// pixel with its column and its row counted from the top, or a single reject result for an
// unsupported format or an oversized image. A byte is taken every cycle while full is low;
// the front end decodes a whole byte at once into a short queue, and the back end puts out
// one result per cycle while pop is high; at 1 bit per pixel a byte yields up to 8 results,
// and the single result port sets the pace. A result is held in the queue and then in the
// back end's current-entry register before it appears on the result ports.
`include "indexed_bmp_stream_decoder_unit_defines.svh"

module indexed_bmp_stream_decoder_unit #(
   parameter int DIM_BITS   = ibsd_pkg::DimBitsDefault,
   parameter int MAX_COLORS = ibsd_pkg::MaxColorsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [7:0]  rsp_pixel_index,
   output logic [7:0]  rsp_palette_slot,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last
);
   import ibsd_pkg::*;

   logic             take, entry_valid, q_read;
   entry_type        entry, q_head;
   queue_status_type q_status;

   assign full = q_status.full;
   assign take = push && !q_status.full;

   ibsd_front #(
      .DIM_BITS   (DIM_BITS),
      .MAX_COLORS (MAX_COLORS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_data_byte),
      .start_of_file (req_start_of_file),
      .entry_valid   (entry_valid),
      .entry         (entry)
   );

   ibsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .write    (take && entry_valid),
      .wr_entry (entry),
      .read     (q_read),
      .rd_entry (q_head),
      .status   (q_status)
   );

   ibsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_read           (q_read),
      .pop              (pop),
      .empty            (empty),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_palette_slot (rsp_palette_slot),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last         (rsp_last)
   );

   // palette entries and rejects each give a single result
   `IBSD_ASSERT_SAME(a_single_is_last, !empty && rsp_kind != KIND_PIXEL, rsp_last,
                     "non-pixel result not last")
   // back end never sits idle while the queue holds work
   `IBSD_ASSERT_NEXT(a_back_loads, empty && !q_status.empty, !empty,
                     "queued entry not loaded")
   // pixels of one byte come out in consecutive columns
   `IBSD_ASSERT_NEXT(a_column_steps, !empty && pop && !rsp_last && rsp_kind == KIND_PIXEL,
                     rsp_pos_x == 16'($past(rsp_pos_x) + 16'd1), "pixel column did not step")

endmodule
